>>> rtl/light_switch_hysteresis_confirm_assert.svh
// Assertion macros for the light switch block and its checker.
// Used by lshc_checker; no other dependencies.
`ifndef LIGHT_SWITCH_HYSTERESIS_CONFIRM_ASSERT_SVH
`define LIGHT_SWITCH_HYSTERESIS_CONFIRM_ASSERT_SVH

// Property checked outside reset.
`define LSHC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every edge, reset included.
`define LSHC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/lshc_pkg.sv
// Shared constants, types and helpers for the light switch block.
// No dependencies.
`default_nettype none

package lshc_pkg;

    localparam int SAMPLE_BITS_DEF = 10;
    localparam int MAX_WINDOW      = 64;
    localparam int THR_W           = 10;
    localparam int WIN_W           = 7;
    localparam int PHASE_W         = 3;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 10;
    localparam int OUT_W           = 16;

    localparam logic [THR_W-1:0] HIGH_THR_RST = 10'd768;
    localparam logic [THR_W-1:0] LOW_THR_RST  = 10'd256;
    localparam logic [WIN_W-1:0] BASE_WIN_RST = 7'd10;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_THR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_THR  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_WIN = 2'd2;

    // phase codes as seen on the output
    localparam logic [PHASE_W-1:0] PH_IDLE        = 3'd0;
    localparam logic [PHASE_W-1:0] PH_CONF_HI     = 3'd1;
    localparam logic [PHASE_W-1:0] PH_CONF_LO     = 3'd2;
    localparam logic [PHASE_W-1:0] PH_WAIT_DARK   = 3'd3;
    localparam logic [PHASE_W-1:0] PH_WAIT_BRIGHT = 3'd4;

    typedef struct packed {
        logic latch;    // capture the accepted sample
        logic step;     // per-phase update with the sample
        logic judge;    // window end: compare sum against high*w or (low+1)*w
        logic publish;  // load the output register
    } t_lshc_cmd;

    typedef struct packed {
        logic win_end;  // this sample closes the confirmation window
        logic out_free; // output register can take a result this cycle
    } t_lshc_sts;

    function automatic logic [WIN_W-1:0] clamp_win(input logic [WIN_W-1:0] w);
        logic [WIN_W-1:0] r;
        r = w;
        if (w == '0)
            r = WIN_W'(1);
        else if (w > WIN_W'(MAX_WINDOW))
            r = WIN_W'(MAX_WINDOW);
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/lshc_ctrl.sv
// Sequencer for the light switch block: input handshake and step order.
// Depends on lshc_pkg.
`default_nettype none

module lshc_ctrl
    import lshc_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_lshc_sts i_sts,
    output t_lshc_cmd      o_cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_STEP  = 2'd1;
    localparam logic [1:0] ST_JUDGE = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_in_ready    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = ST_STEP;
                end
            end
            ST_STEP: begin
                o_cmd.step = 1'b1;
                n_state    = i_sts.win_end ? ST_JUDGE : ST_DONE;
            end
            ST_JUDGE: begin
                o_cmd.judge = 1'b1;
                n_state     = ST_DONE;
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.publish = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_state <= ST_IDLE;
        else
            r_state <= n_state;
    end

endmodule

`default_nettype wire

>>> rtl/lshc_dp.sv
// Datapath for the light switch block: config registers, phase state,
// window sum and count, threshold product and output register. Uses lshc_pkg.
`default_nettype none

module lshc_dp
    import lshc_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic [SAMPLE_BITS-1:0] i_sample,
    input  wire t_lshc_cmd              i_cmd,
    output t_lshc_sts                   o_sts,
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output logic [OUT_W-1:0]            o_out_data
);

    localparam int SUM_W  = SAMPLE_BITS + WIN_W;
    localparam int PROD_W = THR_W + 1 + WIN_W;
    localparam int CMP_W  = (SUM_W > PROD_W) ? SUM_W : PROD_W;
    localparam int LVL_W  = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;

    logic [THR_W-1:0]       r_high;
    logic [THR_W-1:0]       r_low;
    logic [WIN_W-1:0]       r_base;
    logic [PHASE_W-1:0]     r_phase;
    logic                   r_closed;
    logic [WIN_W-1:0]       r_win;
    logic [WIN_W-1:0]       r_cnt;
    logic [SUM_W-1:0]       r_sum;
    logic [SAMPLE_BITS-1:0] r_sample;
    logic [PROD_W-1:0]      r_prod;
    logic                   r_out_valid;
    logic [OUT_W-1:0]       r_out_data;

    logic [PHASE_W-1:0]     n_phase;
    logic                   n_closed;
    logic [WIN_W-1:0]       n_win;
    logic [WIN_W-1:0]       n_cnt;
    logic [SUM_W-1:0]       n_sum;

    logic [LVL_W-1:0]       s_lvl;
    logic [LVL_W-1:0]       hi_lvl;
    logic [LVL_W-1:0]       lo_lvl;
    logic [WIN_W:0]         cnt_inc;
    logic                   confirming;
    logic [THR_W:0]         thr_op;
    logic [PROD_W-1:0]      prod_c;
    logic                   sum_ge;
    logic [WIN_W-1:0]       win_grown;

    assign s_lvl      = LVL_W'(r_sample);
    assign hi_lvl     = LVL_W'(r_high);
    assign lo_lvl     = LVL_W'(r_low);
    assign cnt_inc    = {1'b0, r_cnt} + (WIN_W+1)'(1);
    assign confirming = (r_phase == PH_CONF_HI) || (r_phase == PH_CONF_LO);

    assign o_sts = '{win_end:  confirming && (cnt_inc >= {1'b0, r_win}),
                     out_free: !r_out_valid || i_out_ready};

    // floor(sum/w) >= high  <=>  sum >= high*w
    // floor(sum/w) <= low   <=>  sum <  (low+1)*w
    assign thr_op = (r_phase == PH_CONF_HI) ? {1'b0, r_high}
                                             : ({1'b0, r_low} + (THR_W+1)'(1));
    assign prod_c = {{WIN_W{1'b0}}, thr_op} * {{(THR_W+1){1'b0}}, r_win};
    assign sum_ge = CMP_W'(r_sum) >= CMP_W'(r_prod);

    assign win_grown = (r_win < WIN_W'(MAX_WINDOW)) ? (r_win + WIN_W'(1)) : r_win;

    always_comb begin
        n_phase  = r_phase;
        n_closed = r_closed;
        n_win    = r_win;
        n_cnt    = r_cnt;
        n_sum    = r_sum;
        if (i_cmd.step) begin
            case (r_phase)
                PH_CONF_HI, PH_CONF_LO: begin
                    n_sum = r_sum + SUM_W'(r_sample);
                    n_cnt = cnt_inc[WIN_W-1:0];
                end
                PH_WAIT_DARK: begin
                    if (s_lvl <= lo_lvl)
                        n_phase = PH_IDLE;
                end
                PH_WAIT_BRIGHT: begin
                    if (s_lvl >= hi_lvl)
                        n_phase = PH_IDLE;
                end
                default: begin
                    n_cnt = '0;
                    n_sum = '0;
                    if (s_lvl > hi_lvl) begin
                        n_phase = PH_CONF_HI;
                    end else if (s_lvl < lo_lvl) begin
                        n_phase = PH_CONF_LO;
                    end else begin
                        n_phase = PH_IDLE;
                        n_win   = clamp_win(r_base);
                    end
                end
            endcase
        end else if (i_cmd.judge) begin
            n_cnt = '0;
            n_sum = '0;
            if (r_phase == PH_CONF_HI) begin
                if (sum_ge) begin
                    n_closed = 1'b0;
                    n_phase  = PH_WAIT_DARK;
                end else begin
                    n_win   = win_grown;
                    n_phase = PH_IDLE;
                end
            end else begin
                if (!sum_ge) begin
                    n_closed = 1'b1;
                    n_phase  = PH_WAIT_BRIGHT;
                end else begin
                    n_win   = win_grown;
                    n_phase = PH_IDLE;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high      <= HIGH_THR_RST;
            r_low       <= LOW_THR_RST;
            r_base      <= BASE_WIN_RST;
            r_phase     <= PH_IDLE;
            r_closed    <= 1'b0;
            r_win       <= clamp_win(BASE_WIN_RST);
            r_cnt       <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_HIGH_THR: r_high <= i_cfg_data;
                    REG_LOW_THR:  r_low  <= i_cfg_data;
                    REG_BASE_WIN: r_base <= i_cfg_data[WIN_W-1:0];
                    default: begin
                    end
                endcase
            end
            r_phase  <= n_phase;
            r_closed <= n_closed;
            r_win    <= n_win;
            r_cnt    <= n_cnt;
            r_sum    <= n_sum;
            if (i_cmd.publish)
                r_out_valid <= 1'b1;
            else if (i_out_ready)
                r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch)
            r_sample <= i_sample;
        if (i_cmd.step && o_sts.win_end)
            r_prod <= prod_c;
        if (i_cmd.publish)
            r_out_data <= {{(OUT_W-WIN_W-PHASE_W-1){1'b0}}, r_win, r_phase, r_closed};
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

>>> rtl/light_switch_hysteresis_confirm.sv
// Light switch with hysteresis and averaged confirmation.
// The result is registered after the sequencer's step and done states, with a
// judge state between them when a sample closes a window and the sum is compared
// against high*w or (low+1)*w; done waits while the output is stalled. A new
// sample waits until the last result is published. Synchronous active-low reset.
// Top level; depends on lshc_pkg, lshc_ctrl, lshc_dp.
`default_nettype none

module light_switch_hysteresis_confirm
    import lshc_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    localparam int IN_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    input  wire logic [IN_W-1:0]       i_s_tdata,   // [SAMPLE_BITS-1:0] sample
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    output logic [OUT_W-1:0]           o_m_tdata,   // [0] switch_closed, [3:1] phase,
                                                    // [10:4] window_now
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_lshc_cmd cmd;
    t_lshc_sts sts;

    assign o_cfg_ready = 1'b1;

    lshc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    lshc_dp #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_sample    (i_s_tdata[SAMPLE_BITS-1:0]),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_m_tvalid),
        .i_out_ready (i_m_tready),
        .o_out_data  (o_m_tdata)
    );

endmodule

`default_nettype wire

>>> rtl/lshc_checker.sv
// Port-level checks for the light switch block, bound to its top level.
// Depends on lshc_pkg and light_switch_hysteresis_confirm_assert.svh.
`default_nettype none
`include "light_switch_hysteresis_confirm_assert.svh"

module lshc_checker
    import lshc_pkg::*;
(
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             o_m_tvalid,
    input wire logic             i_m_tready,
    input wire logic [OUT_W-1:0] o_m_tdata
);

    logic               closed;
    logic [PHASE_W-1:0] phase;
    logic [WIN_W-1:0]   win;

    assign closed = o_m_tdata[0];
    assign phase  = o_m_tdata[3:1];
    assign win    = o_m_tdata[10:4];

    // a stalled result holds
    `LSHC_ASSERT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata), "stalled result changed")

    // reset empties the output register
    `LSHC_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !o_m_tvalid, "result valid after reset")

    `LSHC_ASSERT(a_win_range, i_clk, i_rst_n, o_m_tvalid |-> (win != '0) && (win <= WIN_W'(MAX_WINDOW)), "window length out of range")

    // waiting for dark means the switch was just opened, and vice versa
    `LSHC_ASSERT(a_wait_dark_open, i_clk, i_rst_n, o_m_tvalid && (phase == PH_WAIT_DARK) |-> !closed, "wait dark with switch closed")

    `LSHC_ASSERT(a_wait_bright_closed, i_clk, i_rst_n, o_m_tvalid && (phase == PH_WAIT_BRIGHT) |-> closed, "wait bright with switch open")

endmodule

bind light_switch_hysteresis_confirm lshc_checker u_lshc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

`default_nettype wire

>>> verif/light_switch_hysteresis_confirm_test.sv
// Testbench for light_switch_hysteresis_confirm: directed and random light samples
// against a cycle-free predictor. Results are checked field by field, in order.
// Depends on lshc_pkg and the block's RTL.
module light_switch_hysteresis_confirm_test;
    import lshc_pkg::*;

    localparam int SAMPLE_W      = SAMPLE_BITS_DEF;
    localparam int TDATA_W       = ((SAMPLE_W + 7) / 8) * 8;
    localparam int SAMPLE_MAX    = (1 << SAMPLE_W) - 1;
    localparam int STALL_LIMIT   = 3000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 6;
    localparam int PHASE_ITEMS   = 200;

    localparam logic [SAMPLE_W-1:0] SAMPLE_TOP = SAMPLE_W'(SAMPLE_MAX);

    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic                closed;
        logic [PHASE_W-1:0]  phase;
        logic [WIN_W-1:0]    window;
    } t_light_report;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  s_tvalid;
    logic                  o_s_tready;
    logic [TDATA_W-1:0]    s_tdata;
    logic                  o_m_tvalid;
    logic                  m_tready;
    logic [OUT_W-1:0]      o_m_tdata;
    logic                  cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // predictor state
    int                  thr_high;
    int                  thr_low;
    int                  base_reg;
    logic [PHASE_W-1:0]  ph_now;
    logic                closed_now;
    int                  win_len_now;
    int                  conf_count;
    int                  conf_sum;

    t_light_report pending_reports[$];
    int            err_count;
    logic          send_gaps;
    logic          recv_stalls;
    logic          hold_output;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    light_switch_hysteresis_confirm u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    function automatic int fit_window(input int w);
        if (w < 1)
            return 1;
        if (w > MAX_WINDOW)
            return MAX_WINDOW;
        return w;
    endfunction

    // Advance the switch state by one sample and queue the report it produces.
    task automatic track_switch(input logic [SAMPLE_W-1:0] s);
        int            v;
        int            w;
        int            avg;
        t_light_report r;
        v = int'(s);
        case (ph_now)
            PH_CONF_HI, PH_CONF_LO: begin
                conf_sum += v;
                conf_count++;
                w = fit_window(win_len_now);
                if (conf_count >= w) begin
                    avg = conf_sum / w;
                    if (ph_now == PH_CONF_HI && avg >= thr_high) begin
                        closed_now = 1'b0;
                        ph_now = PH_WAIT_DARK;
                    end else if (ph_now == PH_CONF_LO && avg <= thr_low) begin
                        closed_now = 1'b1;
                        ph_now = PH_WAIT_BRIGHT;
                    end else begin
                        if (win_len_now < MAX_WINDOW)
                            win_len_now++;
                        ph_now = PH_IDLE;
                    end
                    conf_count = 0;
                    conf_sum = 0;
                end
            end
            PH_WAIT_DARK: begin
                if (v <= thr_low)
                    ph_now = PH_IDLE;
            end
            PH_WAIT_BRIGHT: begin
                if (v >= thr_high)
                    ph_now = PH_IDLE;
            end
            default: begin
                conf_count = 0;
                conf_sum = 0;
                // bright is tested first, so crossed thresholds favor opening
                if (v > thr_high) begin
                    ph_now = PH_CONF_HI;
                end else if (v < thr_low) begin
                    ph_now = PH_CONF_LO;
                end else begin
                    ph_now = PH_IDLE;
                    win_len_now = fit_window(base_reg);
                end
            end
        endcase
        r.closed = closed_now;
        r.phase  = ph_now;
        r.window = WIN_W'(win_len_now);
        pending_reports.push_back(r);
    endtask

    function automatic logic [SAMPLE_W-1:0] level_between(input int lo, input int hi);
        if (lo < 0)
            lo = 0;
        if (hi > SAMPLE_MAX)
            hi = SAMPLE_MAX;
        if (lo > hi)
            return SAMPLE_W'($urandom_range(SAMPLE_MAX, 0));
        return SAMPLE_W'($urandom_range(hi, lo));
    endfunction

    // Mostly samples that carry the current phase forward, with some noise.
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int r;
        r = $urandom_range(9, 0);
        if ($urandom_range(19, 0) == 0)
            return SAMPLE_W'($urandom_range(SAMPLE_MAX, 0));
        case (ph_now)
            PH_CONF_HI:
                return (r < 6) ? level_between(thr_high, SAMPLE_MAX)
                               : level_between(thr_high - 100, thr_high + 20);
            PH_CONF_LO:
                return (r < 6) ? level_between(0, thr_low)
                               : level_between(thr_low - 20, thr_low + 100);
            PH_WAIT_DARK:
                return (r < 3) ? level_between(0, thr_low)
                               : level_between(thr_low + 1, SAMPLE_MAX);
            PH_WAIT_BRIGHT:
                return (r < 3) ? level_between(thr_high, SAMPLE_MAX)
                               : level_between(0, thr_high - 1);
            default: begin
                if (r < 4)
                    return level_between(thr_high + 1, SAMPLE_MAX);
                if (r < 8)
                    return level_between(0, thr_low - 1);
                return level_between(thr_low, thr_high);
            end
        endcase
    endfunction

    task automatic send_sample(input logic [SAMPLE_W-1:0] s);
        int gap;
        gap = (send_gaps && $urandom_range(4, 0) == 0) ? $urandom_range(9, 1) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = TDATA_W'(s);
        do @(posedge i_clk); while (!o_s_tready);
        track_switch(s);
    endtask

    // Stop offering samples and let every report come out.
    task automatic settle();
        @(negedge i_clk);
        s_tvalid = 1'b0;
        while (pending_reports.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        settle();
        @(negedge i_clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = d;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_HIGH_THR: thr_high = int'(d);
            REG_LOW_THR:  thr_low  = int'(d);
            REG_BASE_WIN: base_reg = int'(d[WIN_W-1:0]);
            default: ;
        endcase
        @(negedge i_clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_levels(input int hi, input int lo, input int base);
        write_reg(REG_HIGH_THR, CFG_DATA_W'(hi));
        write_reg(REG_LOW_THR, CFG_DATA_W'(lo));
        write_reg(REG_BASE_WIN, CFG_DATA_W'(base));
    endtask

    // Reset thresholds and window; a base write must not touch a running window.
    task automatic test_reset_values();
        send_sample(500);
        send_sample(SAMPLE_TOP);
        set_levels(600, 300, 1);
        repeat (10) send_sample(700);
    endtask

    // Equality at idle, wait-exit and low-confirm thresholds; failed confirmations.
    task automatic test_thresholds_and_window();
        send_sample(301);
        send_sample(300);
        send_sample(450);
        send_sample(0);
        send_sample(300);
        send_sample(599);
        send_sample(600);
        send_sample(601);
        send_sample(599);
        send_sample(299);
        send_sample(301);
        send_sample(301);
        send_sample(600);
        send_sample(300);
    endtask

    // Base window of zero and above the bound, unused index, saturation at the bound.
    task automatic test_base_clamp();
        write_reg(REG_BASE_WIN, CFG_DATA_W'(0));
        send_sample(450);
        write_reg(REG_BASE_WIN, 10'h3FF);
        send_sample(450);
        write_reg(REG_BASE_WIN, CFG_DATA_W'(MAX_WINDOW + 1));
        send_sample(450);
        write_reg(REG_UNUSED, CFG_DATA_W'($urandom_range(1023, 0)));
        send_sample(SAMPLE_TOP);
        repeat (MAX_WINDOW) send_sample(SAMPLE_W'($urandom_range(599, 0)));
        send_sample(450);
        write_reg(REG_BASE_WIN, CFG_DATA_W'(2));
        send_sample(450);
    endtask

    task automatic test_crossed_thresholds();
        set_levels(100, 900, 2);
        send_sample(500);
        send_sample(50);
        send_sample(50);
        send_sample(50);
        repeat (3) send_sample(950);
        set_levels(SAMPLE_MAX, 0, 2);
        send_sample(SAMPLE_TOP);
        send_sample(0);
        set_levels(0, SAMPLE_MAX, 2);
        send_sample(0);
        send_sample(SAMPLE_TOP);
        send_sample(SAMPLE_TOP);
        send_sample(5);
    endtask

    // Output held off long enough that the block backs up into its input.
    task automatic test_backpressure();
        set_levels(600, 300, 2);
        send_gaps   = 1'b0;
        hold_output = 1'b1;
        repeat (40) send_sample(pick_sample());
    endtask

    task automatic test_random_phases();
        int hi_tab[5]   = '{768, 1023, 0, 512, 900};
        int lo_tab[5]   = '{256, 0, 1023, 511, 100};
        int base_tab[5] = '{10, 1, 3, 2, 10'h3FF};
        int hi;
        int lo;
        int base;
        for (int p = 0; p < 8; p++) begin
            if (p < 5) begin
                hi   = hi_tab[p];
                lo   = lo_tab[p];
                base = base_tab[p];
            end else begin
                lo   = $urandom_range(600, 0);
                hi   = $urandom_range(SAMPLE_MAX, lo);
                base = $urandom_range(8, 1);
            end
            set_levels(hi, lo, base);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 50 == 0) begin
                    send_gaps   = ($urandom_range(2, 0) != 0);
                    recv_stalls = ($urandom_range(2, 0) != 0);
                end
                send_sample(pick_sample());
            end
        end
    endtask

    task automatic test_final_stretch();
        send_gaps   = 1'b0;
        recv_stalls = 1'b0;
        set_levels(700, 300, 3);
        repeat (180) send_sample(pick_sample());
    endtask

    // receiver: random stall bursts, plus one long hold on request
    initial begin
        int n;
        m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_output) begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_output = 1'b0;
            end else if (recv_stalls && $urandom_range(4, 0) == 0) begin
                m_tready = 1'b0;
                n = $urandom_range(9, 1);
                repeat (n - 1) @(negedge i_clk);
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_light_report want;
        if (i_rst_n && o_m_tvalid && m_tready) begin
            if (pending_reports.size() == 0) begin
                err_count++;
                $error("result with no sample pending: tdata %h", o_m_tdata);
            end else begin
                want = pending_reports.pop_front();
                if (o_m_tdata[0] !== want.closed) begin
                    err_count++;
                    $error("switch_closed: expected %0d, got %0d", want.closed, o_m_tdata[0]);
                end
                if (o_m_tdata[3:1] !== want.phase) begin
                    err_count++;
                    $error("phase: expected %0d, got %0d", want.phase, o_m_tdata[3:1]);
                end
                if (o_m_tdata[10:4] !== want.window) begin
                    err_count++;
                    $error("window_now: expected %0d, got %0d", want.window, o_m_tdata[10:4]);
                end
            end
        end
    end

    // watchdog: ends the run after too long without any transfer
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_tvalid && o_s_tready) || (o_m_tvalid && m_tready)
                    || (cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        i_rst_n     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        cfg_valid   = 1'b0;
        cfg_index   = REG_HIGH_THR;
        cfg_data    = '0;
        send_gaps   = 1'b1;
        recv_stalls = 1'b1;
        hold_output = 1'b0;
        err_count   = 0;
        thr_high    = int'(HIGH_THR_RST);
        thr_low     = int'(LOW_THR_RST);
        base_reg    = int'(BASE_WIN_RST);
        ph_now      = PH_IDLE;
        closed_now  = 1'b0;
        win_len_now = fit_window(int'(BASE_WIN_RST));
        conf_count  = 0;
        conf_sum    = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_values();
        test_thresholds_and_window();
        test_base_clamp();
        test_crossed_thresholds();
        test_backpressure();
        test_random_phases();
        test_final_stretch();

        settle();
        repeat (10) @(posedge i_clk);
        if (pending_reports.size() != 0) begin
            err_count++;
            $error("%0d results never arrived", pending_reports.size());
        end
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/lshc_pkg.sv
rtl/lshc_ctrl.sv
rtl/lshc_dp.sv
rtl/light_switch_hysteresis_confirm.sv
rtl/lshc_checker.sv
verif/light_switch_hysteresis_confirm_test.sv
